[rtl/core/supply_voltage_window_monitor_top_defines.svh]
// Assertion macros for the supply voltage window monitor.
// SVWM_CHECK holds a condition at every clock edge out of reset.
// SVWM_CHECK_NEXT checks that a condition in one cycle implies another in the next.
`ifndef SUPPLY_VOLTAGE_WINDOW_MONITOR_TOP_DEFINES_SVH
`define SUPPLY_VOLTAGE_WINDOW_MONITOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVWM_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define SVWM_CHECK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SVWM_CHECK(label, cond, msg)
`define SVWM_CHECK_NEXT(label, pre, post, msg)
`endif
`endif

[rtl/core/svwm_pkg.sv]
package svwm_pkg;

	// Field and counter widths.
	localparam int MV_W    = 16;
	localparam int STAT_W  = 2;
	localparam int WIN_W   = 8;
	localparam int OU_W    = 5;
	localparam int WIN_MAX = (1 << WIN_W) - 1;
	localparam int OU_MAX  = (1 << OU_W) - 1;

	// Configuration register indexes.
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = 3;
	localparam logic [IDX_W-1:0] REG_OVER_LIMIT    = 3'd0;
	localparam logic [IDX_W-1:0] REG_UNDER_LIMIT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GOOD_UPPER    = 3'd2;
	localparam logic [IDX_W-1:0] REG_GOOD_LOWER    = 3'd3;
	localparam logic [IDX_W-1:0] REG_BAD_UPPER     = 3'd4;
	localparam logic [IDX_W-1:0] REG_BAD_LOWER     = 3'd5;
	localparam logic [IDX_W-1:0] REG_OVER_RELEASE  = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNDER_RELEASE = 3'd7;

	typedef logic [MV_W-1:0] mv_t;
	typedef mv_t regs_t [NUM_REGS];

	// Reset values of the threshold registers, in index order.
	localparam regs_t REG_RESET = '{
		16'd60000, 16'd36000, 16'd58000, 16'd40000,
		16'd59000, 16'd38000, 16'd56000, 16'd42000
	};

	// Supply status codes.
	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_UNKNOWN = 2'd0;
	localparam status_t ST_NORMAL  = 2'd1;
	localparam status_t ST_OVER    = 2'd2;
	localparam status_t ST_UNDER   = 2'd3;

	// Default debounce lengths in samples.
	localparam int unsigned OVER_TICKS_DEF  = 20;
	localparam int unsigned UNDER_TICKS_DEF = 20;
	localparam int unsigned GOOD_TICKS_DEF  = 200;
	localparam int unsigned BAD_TICKS_DEF   = 20;

	// Saturating up/down step: up stops at the limit, down stops at zero.
	function automatic logic [WIN_W-1:0] sat_count(input logic [WIN_W-1:0] cnt,
			input logic up, input logic [WIN_W-1:0] lim);
		logic [WIN_W-1:0] res;
		res = cnt;
		if (up) begin
			if (cnt < lim) res = cnt + 1'b1;
		end else if (cnt != '0) begin
			res = cnt - 1'b1;
		end
		return res;
	endfunction

endpackage

[rtl/core/supply_voltage_window_monitor_top.sv]
// Supply voltage window monitor: one millivolt sample per request, one status result per
// sample. The status (unknown, normal, overvoltage, undervoltage) is debounced by
// saturating counters and every status change clears all counters. A sample is taken
// every cycle while the result side keeps up. A sample lands in the input register when
// accepted; the status registers that form the result update as it advances into the
// result register. The result side's stall passes combinationally to the input stall
// when the input and result registers are both full, so one stalled result holds back
// at most one more sample. The user must write thresholds through the configuration
// port only while no sample is in flight; the block itself does not enforce this.
`include "supply_voltage_window_monitor_top_defines.svh"

module supply_voltage_window_monitor_top #(
	parameter int unsigned OVER_TICKS  = svwm_pkg::OVER_TICKS_DEF,
	parameter int unsigned UNDER_TICKS = svwm_pkg::UNDER_TICKS_DEF,
	parameter int unsigned GOOD_TICKS  = svwm_pkg::GOOD_TICKS_DEF,
	parameter int unsigned BAD_TICKS   = svwm_pkg::BAD_TICKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_wr_en,
	input  logic [svwm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [svwm_pkg::MV_W-1:0]     cfg_data,
	// Sample channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [svwm_pkg::MV_W-1:0]     sample_mv,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [svwm_pkg::STAT_W-1:0]   supply_status,
	output logic                          supply_ok
);

	// Debounce limits, clamped to what each counter can hold.
	localparam logic [svwm_pkg::WIN_W-1:0] LimOver = (OVER_TICKS > svwm_pkg::OU_MAX) ?
		svwm_pkg::WIN_W'(svwm_pkg::OU_MAX) : svwm_pkg::WIN_W'(OVER_TICKS);
	localparam logic [svwm_pkg::WIN_W-1:0] LimUnder = (UNDER_TICKS > svwm_pkg::OU_MAX) ?
		svwm_pkg::WIN_W'(svwm_pkg::OU_MAX) : svwm_pkg::WIN_W'(UNDER_TICKS);
	localparam logic [svwm_pkg::WIN_W-1:0] LimGood = (GOOD_TICKS > svwm_pkg::WIN_MAX) ?
		svwm_pkg::WIN_W'(svwm_pkg::WIN_MAX) : svwm_pkg::WIN_W'(GOOD_TICKS);
	localparam logic [svwm_pkg::WIN_W-1:0] LimBad = (BAD_TICKS > svwm_pkg::WIN_MAX) ?
		svwm_pkg::WIN_W'(svwm_pkg::WIN_MAX) : svwm_pkg::WIN_W'(BAD_TICKS);

	svwm_pkg::regs_t               cfg_q;
	logic                          valid_s1;
	svwm_pkg::mv_t                 sample_s1;
	logic                          out_valid_s2;
	svwm_pkg::status_t             status_q;
	logic                          ok_q;
	logic [svwm_pkg::WIN_W-1:0]    win_q;
	logic [svwm_pkg::OU_W-1:0]     over_q;
	logic [svwm_pkg::OU_W-1:0]     under_q;

	logic                          adv_s1;
	logic                          over_up;
	logic                          under_up;
	logic                          win_up;
	logic [svwm_pkg::WIN_W-1:0]    win_lim;
	logic [svwm_pkg::WIN_W-1:0]    win_nx;
	logic [svwm_pkg::OU_W-1:0]     over_nx;
	logic [svwm_pkg::OU_W-1:0]     under_nx;
	logic                          go;
	svwm_pkg::status_t             go_status;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= svwm_pkg::REG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Handshake: the input register moves on when the result register is free.
	assign adv_s1   = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (!out_valid_s2 || !out_stall) out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) sample_s1 <= sample_mv;
	end

	// Condition decode and counter update for the current status.
	always_comb begin
		over_up   = sample_s1 > cfg_q[svwm_pkg::REG_OVER_LIMIT];
		under_up  = sample_s1 < cfg_q[svwm_pkg::REG_UNDER_LIMIT];
		win_up    = 1'b0;
		win_lim   = LimGood;
		over_nx   = over_q;
		under_nx  = under_q;
		go        = 1'b0;
		go_status = svwm_pkg::ST_UNKNOWN;
		unique case (status_q)
			svwm_pkg::ST_UNKNOWN: begin
				win_up = (sample_s1 < cfg_q[svwm_pkg::REG_GOOD_UPPER]) &&
					(sample_s1 > cfg_q[svwm_pkg::REG_GOOD_LOWER]);
			end
			svwm_pkg::ST_NORMAL: begin
				win_up = (sample_s1 > cfg_q[svwm_pkg::REG_BAD_UPPER]) ||
					(sample_s1 < cfg_q[svwm_pkg::REG_BAD_LOWER]);
				win_lim = LimBad;
			end
			svwm_pkg::ST_OVER: begin
				win_up = sample_s1 < cfg_q[svwm_pkg::REG_OVER_RELEASE];
			end
			default: begin
				win_up = sample_s1 > cfg_q[svwm_pkg::REG_UNDER_RELEASE];
			end
		endcase

		win_nx = svwm_pkg::sat_count(win_q, win_up, win_lim);
		if (status_q == svwm_pkg::ST_UNKNOWN || status_q == svwm_pkg::ST_NORMAL) begin
			over_nx  = svwm_pkg::OU_W'(svwm_pkg::sat_count(svwm_pkg::WIN_W'(over_q),
				over_up, LimOver));
			under_nx = svwm_pkg::OU_W'(svwm_pkg::sat_count(svwm_pkg::WIN_W'(under_q),
				under_up, LimUnder));
		end

		// Transition choice, in the priority each status defines.
		unique case (status_q)
			svwm_pkg::ST_UNKNOWN: begin
				priority if (svwm_pkg::WIN_W'(over_nx) >= LimOver) begin
					go = 1'b1; go_status = svwm_pkg::ST_OVER;
				end else if (svwm_pkg::WIN_W'(under_nx) >= LimUnder) begin
					go = 1'b1; go_status = svwm_pkg::ST_UNDER;
				end else if (win_nx >= LimGood) begin
					go = 1'b1; go_status = svwm_pkg::ST_NORMAL;
				end
			end
			svwm_pkg::ST_NORMAL: begin
				priority if (win_nx >= LimBad) begin
					go = 1'b1; go_status = svwm_pkg::ST_UNKNOWN;
				end else if (svwm_pkg::WIN_W'(over_nx) >= LimOver) begin
					go = 1'b1; go_status = svwm_pkg::ST_OVER;
				end else if (svwm_pkg::WIN_W'(under_nx) >= LimUnder) begin
					go = 1'b1; go_status = svwm_pkg::ST_UNDER;
				end
			end
			default: begin
				go        = win_nx >= LimGood;
				go_status = svwm_pkg::ST_UNKNOWN;
			end
		endcase
	end

	// Status and counters; a transition clears every counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= svwm_pkg::ST_UNKNOWN;
			ok_q     <= 1'b0;
			win_q    <= '0;
			over_q   <= '0;
			under_q  <= '0;
		end else if (adv_s1) begin
			if (go) begin
				status_q <= go_status;
				ok_q     <= go_status == svwm_pkg::ST_NORMAL;
				win_q    <= '0;
				over_q   <= '0;
				under_q  <= '0;
			end else begin
				win_q   <= win_nx;
				over_q  <= over_nx;
				under_q <= under_nx;
			end
		end
	end

	// The status registers hold the latest result until the next sample advances.
	assign out_valid     = out_valid_s2;
	assign supply_status = status_q;
	assign supply_ok     = ok_q;

	`SVWM_CHECK(a_ok_matches_status, ok_q == (status_q == svwm_pkg::ST_NORMAL),
		"ok flag disagrees with status")
	`SVWM_CHECK(a_ou_idle_outside, (status_q == svwm_pkg::ST_UNKNOWN ||
		status_q == svwm_pkg::ST_NORMAL) || (over_q == '0 && under_q == '0),
		"over/under counters active in a fault status")
	`SVWM_CHECK(a_change_clears, $stable(status_q) ||
		(win_q == '0 && over_q == '0 && under_q == '0),
		"status change left a counter set")
	`SVWM_CHECK(a_ou_below_limit, svwm_pkg::WIN_W'(over_q) < LimOver &&
		svwm_pkg::WIN_W'(under_q) < LimUnder, "debounce counter passed its limit")
	`SVWM_CHECK_NEXT(a_result_follows, adv_s1, out_valid_s2,
		"advanced sample produced no result")

endmodule
